// File: rtl/sm3_pkg.sv
// ----------------------------------------------------------------------------
// sm3_pkg: shared types and constants for the SM3 hash block
// Controller states, command/status structs, IV reset values, round helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package sm3_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumIv   = 8;
  localparam int unsigned Rounds  = 64;

  localparam logic [31:0] T_LOW  = 32'h79CC4519;
  localparam logic [31:0] T_HIGH = 32'h7A879D8A;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam logic [31:0] IV_RESET [NumIv] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINISH,
    ST_PAD,
    ST_EMIT
  } sm3_state_t;

  // word source for the block buffer
  typedef enum logic [1:0] {
    SRC_MSG,
    SRC_ZERO,
    SRC_LEN_HI,
    SRC_LEN_LO
  } sm3_src_t;

  typedef struct packed {
    logic     start_msg;   // load chain from IV, clear length
    logic     put_word;    // write a word into the block buffer
    sm3_src_t src;
    logic     add_len;     // add the input word's bit count
    logic     start_blk;   // load working vars from chain value
    logic     do_round;
    logic     finish_blk;  // fold working vars into chain value
    logic     emit_next;
  } sm3_cmd_t;

  typedef struct packed {
    logic [3:0] word_slot;
    logic       last_round;
    logic       pad_pending;  // 0x80 word still owed after a full final word
  } sm3_status_t;

  function automatic logic [31:0] rol32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ {x[22:0], x[31:23]} ^ {x[14:0], x[31:15]};
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ {x[16:0], x[31:17]} ^ {x[8:0], x[31:9]};
  endfunction

endpackage
`default_nettype wire

// File: rtl/sm3_if.sv
// ----------------------------------------------------------------------------
// sm3_if: valid/ready channel interfaces
// Input words, digest words and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none
interface sm3_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic [2:0]  valid_bytes;
  logic        last_word;
  modport source (output valid, message_word, valid_bytes, last_word, input ready);
  modport sink   (input valid, message_word, valid_bytes, last_word, output ready);
endinterface

interface sm3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  digest_index;
  logic        digest_last;
  modport source (output valid, digest_word, digest_index, digest_last, input ready);
  modport sink   (input valid, digest_word, digest_index, digest_last, output ready);
endinterface

interface sm3_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/sm3_message_hash.sv
// ----------------------------------------------------------------------------
// sm3_message_hash: streaming SM3 hash with SM3 padding
// Takes big-endian message words, pads, compresses, returns 8 digest words.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                 | handshake
//  in_     | in  | message_word[32] valid_bytes[3] last    | valid/ready
//  out_    | out | digest_word[32] digest_index[3] last    | valid/ready
//  cfg_    | in  | index[3] data[32] (iv_word_0..7)        | valid/ready
//
// A non-final word is written straight into the block buffer; the 16th word
// of a block also starts the rounds (one shared round unit), then a fold
// into the chain value. The final word adds padding writes (one per
// remaining slot), one or two compressions, then the 8 digest words.
// Reset is synchronous, active low, and restores the standard IV. in_ready
// is low outside the idle state (padding, rounds, fold, digest output);
// out_ready low holds the current digest word.
// ----------------------------------------------------------------------------
`default_nettype none
module sm3_message_hash (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sm3_in_if.sink     in_ch,
  sm3_out_if.source  out_ch,
  sm3_cfg_if.sink    cfg_ch
);
  import sm3_pkg::*;

  sm3_cmd_t    cmd;
  sm3_status_t status;
  logic [2:0]  emit_idx;

  assign cfg_ch.ready = 1'b1;

  sm3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_last   (in_ch.last_word),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_last  (out_ch.digest_last),
    .emit_idx  (emit_idx),
    .cmd       (cmd),
    .status    (status)
  );

  sm3_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_word      (in_ch.message_word),
    .in_nbytes    (in_ch.last_word ? in_ch.valid_bytes : 3'd4),
    .cfg_we       (cfg_ch.valid),
    .cfg_idx      (cfg_ch.index),
    .cfg_data     (cfg_ch.data),
    .digest_word  (out_ch.digest_word),
    .digest_index (emit_idx)
  );

  assign out_ch.digest_index = emit_idx;
endmodule
`default_nettype wire

// File: rtl/sm3_datapath.sv
// ----------------------------------------------------------------------------
// sm3_datapath: block buffer, message expansion, one compression round/cycle
// Holds IV, chain value, working variables, 16-word window and bit length.
// ----------------------------------------------------------------------------
`default_nettype none
module sm3_datapath (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire sm3_pkg::sm3_cmd_t cmd,
  output sm3_pkg::sm3_status_t  status,
  input  wire logic [31:0]      in_word,
  input  wire logic [2:0]       in_nbytes,
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_idx,
  input  wire logic [31:0]      cfg_data,
  output logic [31:0]           digest_word,
  output logic [2:0]            digest_index
);
  import sm3_pkg::*;

  logic [31:0] iv_r    [NumIv];
  logic [31:0] chain_r [NumIv];
  logic [31:0] v_r     [NumIv];
  logic [31:0] w_r     [16];     // sliding window: w_r[0] is W[j]
  logic [63:0] len_r;
  logic [3:0]  slot_r;
  logic [5:0]  rnd_r;
  logic [2:0]  emit_r;

  // pending 0x80 word when final word was full
  logic nb_pad_r;

  logic [31:0] wr_word, w_new, t_rot, a12, ss1, ss2, ff, gg, tt1, tt2;
  logic [2:0]  nb;
  logic [31:0] keep;
  logic [3:0]  put_slot;

  assign status.word_slot   = slot_r;
  assign status.last_round  = (rnd_r == 6'd63);
  assign status.pad_pending = nb_pad_r;
  assign digest_word  = chain_r[emit_r];
  assign digest_index = emit_r;

  // a new message always fills from slot 0
  assign put_slot = cmd.start_msg ? 4'd0 : slot_r;

  always_comb begin
    nb = (in_nbytes > 3'd4) ? 3'd4 : in_nbytes;
    case (nb)
      3'd0:    keep = 32'h0;
      3'd1:    keep = 32'hFF000000;
      3'd2:    keep = 32'hFFFF0000;
      3'd3:    keep = 32'hFFFFFF00;
      default: keep = 32'hFFFFFFFF;
    endcase
    case (cmd.src)
      SRC_MSG:    wr_word = (in_word & keep) |
                            ((nb == 3'd4) ? 32'h0 : ({24'h0, PAD_BYTE} << (5'd24 - {nb[1:0], 3'b0})));
      SRC_ZERO:   wr_word = (nb_pad_r) ? 32'h80000000 : 32'h0;
      SRC_LEN_HI: wr_word = len_r[63:32];
      default:    wr_word = len_r[31:0];
    endcase
  end

  always_comb begin
    w_new = perm1(w_r[0] ^ w_r[7] ^ rol32(w_r[13], 5'd15)) ^ rol32(w_r[3], 5'd7) ^ w_r[10];
    t_rot = rol32((rnd_r < 6'd16) ? T_LOW : T_HIGH, rnd_r[4:0]);
    a12   = rol32(v_r[0], 5'd12);
    ss1   = rol32(a12 + v_r[4] + t_rot, 5'd7);
    ss2   = ss1 ^ a12;
    ff    = (rnd_r < 6'd16) ? (v_r[0] ^ v_r[1] ^ v_r[2])
          : ((v_r[0] & v_r[1]) | (v_r[0] & v_r[2]) | (v_r[1] & v_r[2]));
    gg    = (rnd_r < 6'd16) ? (v_r[4] ^ v_r[5] ^ v_r[6])
          : ((v_r[4] & v_r[5]) | (~v_r[4] & v_r[6]));
    tt1   = ff + v_r[3] + ss2 + (w_r[0] ^ w_r[4]);
    tt2   = gg + v_r[7] + ss1 + w_r[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumIv; i++) begin
        iv_r[i]    <= IV_RESET[i];
        chain_r[i] <= '0;
        v_r[i]     <= '0;
      end
      len_r    <= '0;
      slot_r   <= '0;
      rnd_r    <= '0;
      emit_r   <= '0;
      nb_pad_r <= 1'b0;
    end else begin
      if (cfg_we) iv_r[cfg_idx] <= cfg_data;
      if (cmd.start_msg) begin
        for (int i = 0; i < NumIv; i++) chain_r[i] <= iv_r[i];
        emit_r <= '0;
      end
      if (cmd.add_len)
        len_r <= (cmd.start_msg ? 64'd0 : len_r) + {58'd0, nb, 3'b0};
      if (cmd.put_word) begin
        w_r[put_slot] <= wr_word;
        slot_r        <= put_slot + 4'd1;
        if (cmd.src == SRC_MSG) nb_pad_r <= (nb == 3'd4);
        else                    nb_pad_r <= 1'b0;
      end
      if (cmd.start_blk) begin
        for (int i = 0; i < NumIv; i++) v_r[i] <= chain_r[i];
        rnd_r <= '0;
      end
      if (cmd.do_round) begin
        v_r[3] <= v_r[2];
        v_r[2] <= rol32(v_r[1], 5'd9);
        v_r[1] <= v_r[0];
        v_r[0] <= tt1;
        v_r[7] <= v_r[6];
        v_r[6] <= rol32(v_r[5], 5'd19);
        v_r[5] <= v_r[4];
        v_r[4] <= perm0(tt2);
        rnd_r  <= rnd_r + 6'd1;
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= w_new;
      end
      if (cmd.finish_blk)
        for (int i = 0; i < NumIv; i++) chain_r[i] <= chain_r[i] ^ v_r[i];
      if (cmd.emit_next) emit_r <= emit_r + 3'd1;
    end
  end
endmodule
`default_nettype wire

// File: rtl/sm3_ctrl.sv
// ----------------------------------------------------------------------------
// sm3_ctrl: sequencer for word intake, padding, rounds and digest output
// ----------------------------------------------------------------------------
`default_nettype none
module sm3_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_last,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_last,
  input  wire logic [2:0]          emit_idx,
  output sm3_pkg::sm3_cmd_t        cmd,
  input  wire sm3_pkg::sm3_status_t status
);
  import sm3_pkg::*;

  sm3_state_t state_r, state_nxt;
  logic       in_msg_r, in_msg_nxt;
  logic       pad_r, pad_nxt;   // block in flight belongs to padding phase
  logic       len_hi_r, len_hi_nxt;  // upper length word already in slot 14

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      in_msg_r <= 1'b0;
      pad_r    <= 1'b0;
      len_hi_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      in_msg_r <= in_msg_nxt;
      pad_r    <= pad_nxt;
      len_hi_r <= len_hi_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_msg_nxt = in_msg_r;
    pad_nxt    = pad_r;
    len_hi_nxt = len_hi_r;
    cmd        = '0;
    cmd.src    = SRC_MSG;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    out_last   = (emit_idx == 3'd7);
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start_msg = !in_msg_r;
          cmd.put_word  = 1'b1;
          cmd.add_len   = 1'b1;
          in_msg_nxt    = 1'b1;
          pad_nxt       = in_last;
          // slot resets on message start, so slot 15 means block full
          if (status.word_slot == 4'd15 && in_msg_r) begin
            cmd.start_blk = 1'b1;
            state_nxt     = ST_ROUND;
          end else if (in_last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.put_word = 1'b1;
        // owed 0x80 word first; length only if both words fit in this block
        if (status.pad_pending) begin
          cmd.src = SRC_ZERO;
        end else if (status.word_slot == 4'd14) begin
          cmd.src    = SRC_LEN_HI;
          len_hi_nxt = 1'b1;
        end else if (status.word_slot == 4'd15 && len_hi_r) begin
          cmd.src = SRC_LEN_LO;
        end else begin
          cmd.src = SRC_ZERO;
        end
        if (status.word_slot == 4'd15) begin
          cmd.start_blk = 1'b1;
          state_nxt     = ST_ROUND;
          if (len_hi_r && !status.pad_pending) begin
            pad_nxt    = 1'b0;
            in_msg_nxt = 1'b0;
            len_hi_nxt = 1'b0;
          end
        end
      end
      ST_ROUND: begin
        cmd.do_round = 1'b1;
        if (status.last_round) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish_blk = 1'b1;
        if (pad_r)          state_nxt = ST_PAD;   // message ended, padding not done
        else if (!in_msg_r) state_nxt = ST_EMIT;
        else                state_nxt = ST_IDLE;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit_next = 1'b1;
          if (emit_idx == 3'd7) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire
